### design/usm_pkg.sv
// ============================================================================
// usm_pkg: shared types, constants and step functions of the UV sphere unit
// Holds the channel structs, the fixed-point angle constants, the arctangent
// table and the single-step functions used by the divider and CORDIC cells.
// ============================================================================
`default_nettype none

package usm_pkg;

    // Sizing
    localparam int CORDIC_STAGES = 16;
    localparam int COUNT_BITS    = 8;
    localparam int DIV_STEPS     = 33;

    localparam logic [7:0] COUNT_MASK = 8'((1 << COUNT_BITS) - 1);

    // Q30 angle constants
    localparam logic [32:0] HALF_PI_Q30       = 33'd1686629713;
    localparam logic [32:0] PI_Q30            = 33'd3373259426;
    localparam logic [32:0] THREE_HALF_PI_Q30 = 33'd5059889139;
    localparam logic [32:0] TWO_PI_Q30        = 33'd6746518852;
    localparam logic [32:0] CORDIC_GAIN       = 33'h0_26DD_3B6A;

    // Operation and result kinds
    localparam logic OP_VERTEX   = 1'b0;
    localparam logic OP_TRIANGLE = 1'b1;
    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_STACK_COUNT  = 3'd0;
    localparam logic [2:0] REG_SECTOR_COUNT = 3'd1;
    localparam logic [2:0] REG_DIAMETER     = 3'd2;
    localparam logic [2:0] REG_CENTER_X     = 3'd3;
    localparam logic [2:0] REG_CENTER_Y     = 3'd4;
    localparam logic [2:0] REG_CENTER_Z     = 3'd5;

    typedef struct packed {
        logic       operation;
        logic [7:0] stack_index;
        logic [7:0] sector_index;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [18:0] pos_x;
        logic [18:0] pos_y;
        logic [18:0] pos_z;
        logic [15:0] tex_s;
        logic [15:0] tex_t;
        logic [15:0] index_a;
        logic [15:0] index_b;
        logic [15:0] index_c;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  stack_count;
        logic [7:0]  sector_count;
        logic [15:0] diameter;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] center_z;
    } cfg_t;

    // Item data that rides alongside the arithmetic
    typedef struct packed {
        logic        kind;
        logic [15:0] k1;
        logic [15:0] k2;
        logic        has_a;
        logic        has_b;
    } tag_t;

    typedef struct packed {
        logic [7:0]  rem;
        logic [32:0] dq;
    } div_lane_t;

    // lanes: 0 stack angle, 1 sector angle, 2 tex_s, 3 tex_t
    typedef div_lane_t [3:0] div_quad_t;

    typedef struct packed {
        logic [32:0] x;
        logic [32:0] y;
        logic [32:0] z;
    } cordic_lane_t;

    // lanes: 0 stack angle, 1 sector angle
    typedef cordic_lane_t [1:0] cordic_pair_t;

    typedef struct packed {
        tag_t        tag;
        logic        neg;
        logic [15:0] tex_s;
        logic [15:0] tex_t;
    } cordic_side_t;

    typedef struct packed {
        tag_t        tag;
        logic [18:0] pos_x;
        logic [18:0] pos_y;
        logic [18:0] pos_z;
        logic [15:0] tex_s;
        logic [15:0] tex_t;
    } post_out_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] k);
        logic [31:0] a;
        case (k)
            5'd0:  a = 32'h3243F6A8;
            5'd1:  a = 32'h1DAC6705;
            5'd2:  a = 32'h0FADBAFC;
            5'd3:  a = 32'h07F56EA6;
            5'd4:  a = 32'h03FEAB76;
            5'd5:  a = 32'h01FFD55B;
            5'd6:  a = 32'h00FFFAAA;
            5'd7:  a = 32'h007FFF55;
            5'd8:  a = 32'h003FFFEA;
            5'd9:  a = 32'h001FFFFD;
            5'd10: a = 32'h000FFFFF;
            5'd11: a = 32'h0007FFFF;
            5'd12: a = 32'h0003FFFF;
            5'd13: a = 32'h0001FFFF;
            5'd14: a = 32'h0000FFFF;
            5'd15: a = 32'h00007FFF;
            5'd16: a = 32'h00003FFF;
            5'd17: a = 32'h00001FFF;
            5'd18: a = 32'h00000FFF;
            5'd19: a = 32'h000007FF;
            5'd20: a = 32'h000003FF;
            5'd21: a = 32'h000001FF;
            5'd22: a = 32'h000000FF;
            5'd23: a = 32'h0000007F;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

    // One restoring-division step: one quotient bit shifted in at the bottom
    function automatic div_lane_t div_step(input div_lane_t l, input logic [7:0] d);
        logic [8:0] t;
        div_lane_t  r;
        t = {l.rem, l.dq[32]};
        if (t >= {1'b0, d}) begin
            r.rem = 8'(t - {1'b0, d});
            r.dq  = {l.dq[31:0], 1'b1};
        end else begin
            r.rem = t[7:0];
            r.dq  = {l.dq[31:0], 1'b0};
        end
        return r;
    endfunction

    // One CORDIC rotation, floor shifts
    function automatic cordic_lane_t cordic_step(input cordic_lane_t l,
                                                 input logic [4:0] sh,
                                                 input logic [31:0] at);
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        cordic_lane_t       r;
        xs = $signed(l.x) >>> sh;
        ys = $signed(l.y) >>> sh;
        if (!l.z[32]) begin
            r.x = 33'($signed(l.x) - ys);
            r.y = 33'($signed(l.y) + xs);
            r.z = 33'(l.z - {1'b0, at});
        end else begin
            r.x = 33'($signed(l.x) + ys);
            r.y = 33'($signed(l.y) - xs);
            r.z = 33'(l.z + {1'b0, at});
        end
        return r;
    endfunction

    // Clamp to the signed 19-bit position range
    function automatic logic [18:0] sat_pos(input logic signed [23:0] v);
        logic [18:0] r;
        if (v > 24'sd262143) begin
            r = 19'h3FFFF;
        end else if (v < -24'sd262144) begin
            r = 19'h40000;
        end else begin
            r = v[18:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/usm_div_cell.sv
// ============================================================================
// usm_div_cell: one cell of the restoring divider chain
// Produces one quotient bit on each of four lanes and registers the result,
// handing the item tag on to the next cell.
// ============================================================================
`default_nettype none

module usm_div_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic [7:0]        stack_div,
    input  wire logic [7:0]        sector_div,
    input  wire logic              valid_in,
    input  wire usm_pkg::tag_t     tag_in,
    input  wire usm_pkg::div_quad_t lanes_in,
    output logic                   valid_out,
    output usm_pkg::tag_t          tag_out,
    output usm_pkg::div_quad_t     lanes_out
);

    logic               valid_reg;
    usm_pkg::tag_t      tag_reg;
    usm_pkg::div_quad_t lanes_reg;
    usm_pkg::div_quad_t lanes_next;

    // stack divisor on angle u and tex_t, sector divisor on angle v and tex_s
    always_comb begin
        lanes_next[0] = usm_pkg::div_step(lanes_in[0], stack_div);
        lanes_next[1] = usm_pkg::div_step(lanes_in[1], sector_div);
        lanes_next[2] = usm_pkg::div_step(lanes_in[2], sector_div);
        lanes_next[3] = usm_pkg::div_step(lanes_in[3], stack_div);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg   <= tag_in;
            lanes_reg <= lanes_next;
        end
    end

    assign valid_out = valid_reg;
    assign tag_out   = tag_reg;
    assign lanes_out = lanes_reg;

endmodule

`default_nettype wire

### design/usm_cordic_cell.sv
// ============================================================================
// usm_cordic_cell: one rotation cell of the sine/cosine chain
// Rotates both angle lanes by one arctangent step and registers them.
// ============================================================================
`default_nettype none

module usm_cordic_cell (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic [4:0]            shift,
    input  wire logic [31:0]           atan,
    input  wire logic                  valid_in,
    input  wire usm_pkg::cordic_side_t side_in,
    input  wire usm_pkg::cordic_pair_t lanes_in,
    output logic                       valid_out,
    output usm_pkg::cordic_side_t      side_out,
    output usm_pkg::cordic_pair_t      lanes_out
);

    logic                  valid_reg;
    usm_pkg::cordic_side_t side_reg;
    usm_pkg::cordic_pair_t lanes_reg;
    usm_pkg::cordic_pair_t lanes_next;

    always_comb begin
        lanes_next[0] = usm_pkg::cordic_step(lanes_in[0], shift, atan);
        lanes_next[1] = usm_pkg::cordic_step(lanes_in[1], shift, atan);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg  <= side_in;
            lanes_reg <= lanes_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign lanes_out = lanes_reg;

endmodule

`default_nettype wire

### design/usm_post.sv
// ============================================================================
// usm_post: radius scaling, centre offset and saturation
// Three registered stages: radius products, second products, rounding with
// the centre added and the 19-bit clamp.
// ============================================================================
`default_nettype none

module usm_post (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire usm_pkg::cfg_t         cfg,
    input  wire logic                  valid_in,
    input  wire usm_pkg::cordic_side_t side_in,
    input  wire usm_pkg::cordic_pair_t lanes_in,
    output logic                       valid_out,
    output usm_pkg::post_out_t         data_out
);

    // stage 1
    logic                  v1_reg;
    usm_pkg::cordic_side_t side1_reg;
    logic signed [49:0]    prc_reg;
    logic signed [49:0]    pz_prod_reg;
    logic signed [32:0]    cv_reg;
    logic signed [32:0]    cs_reg;
    // stage 2
    logic                  v2_reg;
    usm_pkg::cordic_side_t side2_reg;
    logic signed [59:0]    pxp_reg;
    logic signed [59:0]    pyp_reg;
    logic [18:0]           pz_reg;
    // stage 3
    logic                  v3_reg;
    usm_pkg::post_out_t    out_reg;

    logic signed [16:0]    diam_s;
    logic signed [32:0]    cv_n;
    logic signed [32:0]    cs_n;
    logic signed [49:0]    rc_round;
    logic signed [26:0]    rc;
    logic signed [49:0]    z_round;
    logic signed [23:0]    z_sum;
    logic signed [59:0]    x_round;
    logic signed [59:0]    y_round;
    logic signed [23:0]    x_sum;
    logic signed [23:0]    y_sum;
    usm_pkg::post_out_t    out_next;

    // stage 1: undo the sector fold, scale by the diameter
    always_comb begin
        diam_s = $signed({1'b0, cfg.diameter});
        cv_n   = side_in.neg ? -$signed(lanes_in[1].x) : $signed(lanes_in[1].x);
        cs_n   = side_in.neg ? -$signed(lanes_in[1].y) : $signed(lanes_in[1].y);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg   <= side_in;
            prc_reg     <= diam_s * $signed(lanes_in[0].x);
            pz_prod_reg <= diam_s * $signed(lanes_in[0].y);
            cv_reg      <= cv_n;
            cs_reg      <= cs_n;
        end
    end

    // stage 2: radius times cos(u) rounded to Q.8, then times cos/sin(v)
    always_comb begin
        rc_round = prc_reg + 50'sd4194304;
        rc       = rc_round[49:23];
        z_round  = pz_prod_reg + 50'sd1073741824;
        z_sum    = {{5{z_round[49]}}, z_round[49:31]}
                 + {{8{cfg.center_z[15]}}, cfg.center_z};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side1_reg;
            pxp_reg   <= rc * cv_reg;
            pyp_reg   <= rc * cs_reg;
            pz_reg    <= usm_pkg::sat_pos(z_sum);
        end
    end

    // stage 3: round, add centre, clamp
    always_comb begin
        x_round = pxp_reg + (60'sd1 <<< 37);
        y_round = pyp_reg + (60'sd1 <<< 37);
        x_sum   = {{2{x_round[59]}}, x_round[59:38]}
                + {{8{cfg.center_x[15]}}, cfg.center_x};
        y_sum   = {{2{y_round[59]}}, y_round[59:38]}
                + {{8{cfg.center_y[15]}}, cfg.center_y};
        out_next.tag   = side2_reg.tag;
        out_next.pos_x = usm_pkg::sat_pos(x_sum);
        out_next.pos_y = usm_pkg::sat_pos(y_sum);
        out_next.pos_z = pz_reg;
        out_next.tex_s = side2_reg.tex_s;
        out_next.tex_t = side2_reg.tex_t;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign valid_out = v3_reg;
    assign data_out  = out_reg;

endmodule

`default_nettype wire

### design/uv_sphere_mesh_generator_unit.sv
// ============================================================================
// uv_sphere_mesh_generator_unit: UV sphere vertex and index generator
// Vertex requests give position and texture coordinates of a grid point;
// cell requests give up to two index triples of a grid quad.
// ============================================================================
//  channel | ports                                  | role
//  --------+----------------------------------------+------------------------
//  in      | s_valid s_ready s_data                 | grid requests
//  out     | m_valid m_ready m_data                 | vertex / triangle results
//  config  | cfg_valid cfg_ready cfg_index cfg_data | register writes
//
//  One request per cycle enters while the chain advances; each request passes
//  the 33 divider cells, the CORDIC cells and three scaling stages.
//  A cell giving two triangles holds the result stage for two transfers.
//  The whole chain advances only when the result stage is empty or its last
//  transfer is taken.
//  Reset clears valid bits and loads the register defaults.
// ============================================================================
`default_nettype none

module uv_sphere_mesh_generator_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire usm_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output usm_pkg::out_item_t     m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);

    localparam int NDIV = usm_pkg::DIV_STEPS;
    localparam int NCOR = usm_pkg::CORDIC_STAGES;

    usm_pkg::cfg_t cfg_reg;
    logic          second_reg;
    logic          en;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stack_count  <= 8'd16;
            cfg_reg.sector_count <= 8'd32;
            cfg_reg.diameter     <= 16'd256;
            cfg_reg.center_x     <= 16'd0;
            cfg_reg.center_y     <= 16'd0;
            cfg_reg.center_z     <= 16'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                usm_pkg::REG_STACK_COUNT:  cfg_reg.stack_count  <= cfg_data[7:0];
                usm_pkg::REG_SECTOR_COUNT: cfg_reg.sector_count <= cfg_data[7:0];
                usm_pkg::REG_DIAMETER:     cfg_reg.diameter     <= cfg_data;
                usm_pkg::REG_CENTER_X:     cfg_reg.center_x     <= cfg_data;
                usm_pkg::REG_CENTER_Y:     cfg_reg.center_y     <= cfg_data;
                usm_pkg::REG_CENTER_Z:     cfg_reg.center_z     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Entry: grid checks, index arithmetic, dividends
    logic [7:0]         st;
    logic [7:0]         se;
    logic               entry_ok;
    logic [16:0]        k1_full;
    logic [40:0]        num_u;
    logic [40:0]        num_v;
    logic [40:0]        num_s;
    logic [40:0]        num_t;
    logic               ent_valid;
    usm_pkg::tag_t      ent_tag;
    usm_pkg::div_quad_t ent_lanes;
    logic               div_valid [NDIV+1];
    usm_pkg::tag_t      div_tag   [NDIV+1];
    usm_pkg::div_quad_t div_lanes [NDIV+1];

    always_comb begin
        st = cfg_reg.stack_count & usm_pkg::COUNT_MASK;
        se = cfg_reg.sector_count & usm_pkg::COUNT_MASK;

        k1_full = 17'(s_data.stack_index) * 17'({1'b0, se} + 9'd1)
                + 17'(s_data.sector_index);
        ent_tag.kind  = s_data.operation;
        ent_tag.k1    = k1_full[15:0];
        ent_tag.k2    = 16'(k1_full + 17'(se) + 17'd1);
        ent_tag.has_a = (s_data.stack_index != 8'd0);
        ent_tag.has_b = (s_data.stack_index != 8'(st - 8'd1));

        if (st == 8'd0 || se == 8'd0) begin
            entry_ok = 1'b0;
        end else if (s_data.operation == usm_pkg::OP_VERTEX) begin
            entry_ok = (s_data.stack_index <= st) && (s_data.sector_index <= se);
        end else begin
            entry_ok = (s_data.stack_index < st) && (s_data.sector_index < se)
                     && (ent_tag.has_a || ent_tag.has_b);
        end

        num_u = 41'(s_data.stack_index) * 41'(usm_pkg::PI_Q30) + 41'(st >> 1);
        num_v = 41'(s_data.sector_index) * 41'(usm_pkg::TWO_PI_Q30) + 41'(se >> 1);
        num_s = (41'(s_data.sector_index) << 15) + 41'(se >> 1);
        num_t = (41'(s_data.stack_index) << 15) + 41'(st >> 1);

        ent_lanes[0] = '{rem: num_u[40:33], dq: num_u[32:0]};
        ent_lanes[1] = '{rem: num_v[40:33], dq: num_v[32:0]};
        ent_lanes[2] = '{rem: num_s[40:33], dq: num_s[32:0]};
        ent_lanes[3] = '{rem: num_t[40:33], dq: num_t[32:0]};
        ent_valid    = s_valid && entry_ok;
    end

    assign div_valid[0] = ent_valid;
    assign div_tag[0]   = ent_tag;
    assign div_lanes[0] = ent_lanes;

    assign s_ready = en;

    // Divider chain: one quotient bit per cell
    for (genvar g = 0; g < NDIV; g++) begin : g_div
        usm_div_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .stack_div  (st),
            .sector_div (se),
            .valid_in   (div_valid[g]),
            .tag_in     (div_tag[g]),
            .lanes_in   (div_lanes[g]),
            .valid_out  (div_valid[g+1]),
            .tag_out    (div_tag[g+1]),
            .lanes_out  (div_lanes[g+1])
        );
    end

    // Angle set-up: stack angle from pi/2, sector angle folded into +-pi/2
    logic                  cor_valid [NCOR+1];
    usm_pkg::cordic_side_t cor_side  [NCOR+1];
    usm_pkg::cordic_pair_t cor_lanes [NCOR+1];
    logic                  set_valid;
    usm_pkg::cordic_side_t set_side;
    usm_pkg::cordic_pair_t set_lanes;
    logic [32:0]           q_u;
    logic [32:0]           q_v;

    always_comb begin
        q_u = div_lanes[NDIV][0].dq;
        q_v = div_lanes[NDIV][1].dq;

        set_side.tag   = div_tag[NDIV];
        set_side.tex_s = div_lanes[NDIV][2].dq[15:0];
        set_side.tex_t = div_lanes[NDIV][3].dq[15:0];
        set_side.neg   = 1'b0;

        set_lanes[0].x = usm_pkg::CORDIC_GAIN;
        set_lanes[0].y = 33'd0;
        set_lanes[0].z = usm_pkg::HALF_PI_Q30 - q_u;
        set_lanes[1].x = usm_pkg::CORDIC_GAIN;
        set_lanes[1].y = 33'd0;
        set_lanes[1].z = q_v;
        if (q_v > usm_pkg::HALF_PI_Q30) begin
            if (q_v < usm_pkg::THREE_HALF_PI_Q30) begin
                set_lanes[1].z = q_v - usm_pkg::PI_Q30;
                set_side.neg   = 1'b1;
            end else begin
                set_lanes[1].z = q_v - usm_pkg::TWO_PI_Q30;
            end
        end
        set_valid = div_valid[NDIV];
    end

    assign cor_valid[0] = set_valid;
    assign cor_side[0]  = set_side;
    assign cor_lanes[0] = set_lanes;

    // CORDIC chain
    for (genvar g = 0; g < NCOR; g++) begin : g_cor
        usm_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .shift     (5'(g)),
            .atan      (usm_pkg::atan_q30(5'(g))),
            .valid_in  (cor_valid[g]),
            .side_in   (cor_side[g]),
            .lanes_in  (cor_lanes[g]),
            .valid_out (cor_valid[g+1]),
            .side_out  (cor_side[g+1]),
            .lanes_out (cor_lanes[g+1])
        );
    end

    // Scaling and result stage
    logic               fin_valid;
    usm_pkg::post_out_t fin;

    usm_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .valid_in  (cor_valid[NCOR]),
        .side_in   (cor_side[NCOR]),
        .lanes_in  (cor_lanes[NCOR]),
        .valid_out (fin_valid),
        .data_out  (fin)
    );

    // Result formatting; a two-triangle cell gives two transfers
    logic two_tri;
    logic first_a;
    logic last_emit;

    always_comb begin
        two_tri   = (fin.tag.kind == usm_pkg::KIND_TRIANGLE)
                  && fin.tag.has_a && fin.tag.has_b;
        first_a   = fin.tag.has_a && !second_reg;
        last_emit = !(two_tri && !second_reg);

        m_data = '0;
        m_data.kind = fin.tag.kind;
        m_data.last = last_emit;
        if (fin.tag.kind == usm_pkg::KIND_VERTEX) begin
            m_data.pos_x = fin.pos_x;
            m_data.pos_y = fin.pos_y;
            m_data.pos_z = fin.pos_z;
            m_data.tex_s = fin.tex_s;
            m_data.tex_t = fin.tex_t;
        end else if (first_a) begin
            m_data.index_a = fin.tag.k1;
            m_data.index_b = fin.tag.k2;
            m_data.index_c = fin.tag.k1 + 16'd1;
        end else begin
            m_data.index_a = fin.tag.k1 + 16'd1;
            m_data.index_b = fin.tag.k2;
            m_data.index_c = fin.tag.k2 + 16'd1;
        end
    end

    assign m_valid = fin_valid;
    assign en      = !fin_valid || (m_ready && last_emit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
        end else if (en) begin
            second_reg <= 1'b0;
        end else if (fin_valid && m_ready && two_tri) begin
            second_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

### dv/usm_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// usm_checker: result predictor and scoreboard for the UV sphere unit
// Watches the request, result and register channels, works out the vertex
// and triangle results of every accepted request and compares each result
// transfer with the oldest one still waiting.
// ============================================================================

module usm_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  usm_pkg::in_item_t   s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  usm_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output int                  errors,
    output int                  pending
);

    localparam longint Q30_PI      = 64'd3373259426;
    localparam longint Q30_HALF_PI = 64'd1686629713;
    localparam longint Q30_TWO_PI  = 64'd6746518852;
    localparam longint Q30_GAIN    = 64'h26DD3B6A;

    // own copy of the register file
    logic [7:0]  n_stacks;
    logic [7:0]  n_sectors;
    logic [15:0] dia;
    logic [15:0] cx, cy, cz;

    usm_pkg::out_item_t expected_results[$];
    int                 fail_cnt;

    assign errors  = fail_cnt;
    assign pending = expected_results.size();

    function automatic longint arctan_step(input int k);
        case (k)
            0:  return 64'h3243F6A8;
            1:  return 64'h1DAC6705;
            2:  return 64'h0FADBAFC;
            3:  return 64'h07F56EA6;
            4:  return 64'h03FEAB76;
            5:  return 64'h01FFD55B;
            6:  return 64'h00FFFAAA;
            7:  return 64'h007FFF55;
            8:  return 64'h003FFFEA;
            9:  return 64'h001FFFFD;
            10: return 64'h000FFFFF;
            11: return 64'h0007FFFF;
            12: return 64'h0003FFFF;
            13: return 64'h0001FFFF;
            14: return 64'h0000FFFF;
            15: return 64'h00007FFF;
            16: return 64'h00003FFF;
            17: return 64'h00001FFF;
            18: return 64'h00000FFF;
            19: return 64'h000007FF;
            20: return 64'h000003FF;
            21: return 64'h000001FF;
            22: return 64'h000000FF;
            23: return 64'h0000007F;
            default: return 64'd0;
        endcase
    endfunction

    // rotation-mode sine/cosine, Q30 in and out
    task automatic rotate(input longint ang, output longint c, output longint s);
        longint x, y, z, nx;
        x = Q30_GAIN;
        y = 0;
        z = ang;
        for (int k = 0; k < usm_pkg::CORDIC_STAGES && k < 24; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - arctan_step(k);
            end else begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + arctan_step(k);
            end
            x = nx;
        end
        c = x;
        s = y;
    endtask

    function automatic longint round_asr(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic [18:0] clamp19(input longint v);
        if (v > 262143)  return 19'h3FFFF;
        if (v < -262144) return 19'h40000;
        return v[18:0];
    endfunction

    // queue one expected result at the back
    task automatic expect_result(input usm_pkg::out_item_t r);
        expected_results = {expected_results, r};
    endtask

    // expected results of one request
    task automatic predict_mesh(input usm_pkg::in_item_t req);
        longint             st, se, i, j, su, sv, cu, ss, cv, cs, rc, k1, k2;
        bit                 flip;
        usm_pkg::out_item_t r;
        st = longint'(n_stacks & usm_pkg::COUNT_MASK);
        se = longint'(n_sectors & usm_pkg::COUNT_MASK);
        i  = longint'(req.stack_index);
        j  = longint'(req.sector_index);
        flip = 1'b0;
        if (st == 0 || se == 0) return;
        if (req.operation == usm_pkg::OP_VERTEX) begin
            if (i > st || j > se) return;
            su = Q30_HALF_PI - (i * Q30_PI + st / 2) / st;
            sv = (j * Q30_TWO_PI + se / 2) / se;
            // fold the sector angle into the CORDIC range
            if (sv > Q30_HALF_PI) begin
                if (sv < Q30_PI + Q30_HALF_PI) begin
                    sv   = sv - Q30_PI;
                    flip = 1'b1;
                end else begin
                    sv = sv - Q30_TWO_PI;
                end
            end
            rotate(su, cu, ss);
            rotate(sv, cv, cs);
            if (flip) begin
                cv = -cv;
                cs = -cs;
            end
            rc = round_asr(longint'(dia) * cu, 23);
            r = '0;
            r.kind  = usm_pkg::KIND_VERTEX;
            r.pos_x = clamp19(round_asr(rc * cv, 38) + longint'($signed(cx)));
            r.pos_y = clamp19(round_asr(rc * cs, 38) + longint'($signed(cy)));
            r.pos_z = clamp19(round_asr(longint'(dia) * ss, 31) + longint'($signed(cz)));
            r.tex_s = 16'((j * 32768 + se / 2) / se);
            r.tex_t = 16'((i * 32768 + st / 2) / st);
            r.last  = 1'b1;
            expect_result(r);
        end else begin
            if (i >= st || j >= se) return;
            k1 = i * (se + 1) + j;
            k2 = k1 + se + 1;
            // upper triangle, absent on the top stack
            if (i != 0) begin
                r = '0;
                r.kind    = usm_pkg::KIND_TRIANGLE;
                r.index_a = 16'(k1);
                r.index_b = 16'(k2);
                r.index_c = 16'(k1 + 1);
                r.last    = (i == st - 1);
                expect_result(r);
            end
            // lower triangle, absent on the bottom stack
            if (i != st - 1) begin
                r = '0;
                r.kind    = usm_pkg::KIND_TRIANGLE;
                r.index_a = 16'(k1 + 1);
                r.index_b = 16'(k2);
                r.index_c = 16'(k2 + 1);
                r.last    = 1'b1;
                expect_result(r);
            end
        end
    endtask

    task automatic report(input string what, input usm_pkg::out_item_t exp_r,
                          input usm_pkg::out_item_t act_r);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t mismatch %s: expected %p actual %p", $realtime, what, exp_r, act_r);
    endtask

    function automatic bit same_result(input usm_pkg::out_item_t a,
                                       input usm_pkg::out_item_t b);
        return a.kind == b.kind && a.pos_x == b.pos_x && a.pos_y == b.pos_y &&
               a.pos_z == b.pos_z && a.tex_s == b.tex_s && a.tex_t == b.tex_t &&
               a.index_a == b.index_a && a.index_b == b.index_b &&
               a.index_c == b.index_c && a.last == b.last;
    endfunction

    initial fail_cnt = 0;

    // sample all three channels at the rising edge
    always @(posedge aclk) begin
        usm_pkg::out_item_t want;
        if (!aresetn) begin
            n_stacks  = 8'd16;
            n_sectors = 8'd32;
            dia       = 16'd256;
            cx        = '0;
            cy        = '0;
            cz        = '0;
        end else begin
            if (s_valid && s_ready)
                predict_mesh(s_data);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", '0, m_data);
                end else begin
                    want = expected_results.pop_front();
                    if (!same_result(want, m_data))
                        report("result field", want, m_data);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    usm_pkg::REG_STACK_COUNT:  n_stacks  = cfg_data[7:0];
                    usm_pkg::REG_SECTOR_COUNT: n_sectors = cfg_data[7:0];
                    usm_pkg::REG_DIAMETER:     dia       = cfg_data;
                    usm_pkg::REG_CENTER_X:     cx        = cfg_data;
                    usm_pkg::REG_CENTER_Y:     cy        = cfg_data;
                    usm_pkg::REG_CENTER_Z:     cz        = cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: stimulus and verdict for the UV sphere mesh generator
// Directed vertex and cell requests at the grid edges, then random requests
// over several grid sizes, diameters and centres, with random gaps on both
// channels and one long result back-pressure stretch.
// ============================================================================

module tb;

    localparam int LATENCY    = usm_pkg::DIV_STEPS + usm_pkg::CORDIC_STAGES + 3;
    localparam int WDOG_LIMIT = 20000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    usm_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    usm_pkg::out_item_t m_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    int                 errors;
    int                 pending;
    bit                 squeeze_req;
    int                 quiet_cycles;
    int                 grid_st;
    int                 grid_se;

    uv_sphere_mesh_generator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    usm_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one request transfer; leaves us on a falling edge
    task automatic send_req(input logic op, input int i, input int j);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = '{operation: op, stack_index: 8'(i), sector_index: 8'(j)};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // drain the pipe, then load a full register set
    task automatic load_grid(input int st, input int se, input int dia,
                             input int x, input int y, input int z);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
        write_reg(usm_pkg::REG_STACK_COUNT, 16'(st));
        write_reg(usm_pkg::REG_SECTOR_COUNT, 16'(se));
        write_reg(usm_pkg::REG_DIAMETER, 16'(dia));
        write_reg(usm_pkg::REG_CENTER_X, 16'(x));
        write_reg(usm_pkg::REG_CENTER_Y, 16'(y));
        write_reg(usm_pkg::REG_CENTER_Z, 16'(z));
        // indexes past the last register must be ignored
        write_reg(3'($urandom_range(6, 7)), 16'($urandom));
        grid_st = st;
        grid_se = se;
    endtask

    // random request, mostly on or just past the grid
    task automatic random_req();
        int i, j;
        if ($urandom_range(0, 9) == 0) begin
            i = $urandom_range(0, 255);
            j = $urandom_range(0, 255);
        end else begin
            i = $urandom_range(0, grid_st + 1);
            j = $urandom_range(0, grid_se + 1);
        end
        send_req(1'($urandom), i, j);
    endtask

    // result side: random ready, one long hold on request
    initial begin
        int hold;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold = 300;
            end
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else if ($urandom_range(0, 99) < 70) begin
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b0;
                hold = gap_len();
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("[uv_sphere_mesh_generator_unit] ERROR");
            $finish;
        end
    end

    initial begin
        quiet_cycles = 0;
        squeeze_req  = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        grid_st      = 16;
        grid_se      = 32;
        aresetn      = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed, reset grid 16 x 32
        send_req(usm_pkg::OP_VERTEX, 0, 0);
        send_req(usm_pkg::OP_VERTEX, 16, 32);
        send_req(usm_pkg::OP_VERTEX, 8, 8);
        send_req(usm_pkg::OP_VERTEX, 8, 24);
        send_req(usm_pkg::OP_VERTEX, 3, 16);
        send_req(usm_pkg::OP_VERTEX, 17, 0);
        send_req(usm_pkg::OP_VERTEX, 0, 33);
        send_req(usm_pkg::OP_VERTEX, 255, 255);
        send_req(usm_pkg::OP_TRIANGLE, 0, 0);
        send_req(usm_pkg::OP_TRIANGLE, 15, 31);
        send_req(usm_pkg::OP_TRIANGLE, 7, 13);
        send_req(usm_pkg::OP_TRIANGLE, 16, 0);
        send_req(usm_pkg::OP_TRIANGLE, 0, 32);
        send_req(usm_pkg::OP_TRIANGLE, 255, 255);

        // a single stack gives no cells, only vertices
        load_grid(1, 255, 65535, 32767, -32768, 32767);
        send_req(usm_pkg::OP_TRIANGLE, 0, 0);
        send_req(usm_pkg::OP_VERTEX, 0, 0);
        send_req(usm_pkg::OP_VERTEX, 1, 255);
        send_req(usm_pkg::OP_VERTEX, 1, 100);
        // zero counts silence everything
        load_grid(0, 32, 256, 0, 0, 0);
        send_req(usm_pkg::OP_VERTEX, 0, 0);
        send_req(usm_pkg::OP_TRIANGLE, 0, 0);
        load_grid(8, 0, 256, 0, 0, 0);
        send_req(usm_pkg::OP_VERTEX, 0, 0);
        send_req(usm_pkg::OP_TRIANGLE, 0, 0);

        // random phases; the widest grid reaches the top of the 16-bit index range
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: load_grid(255, 255, 65535, -32768, -32768, -32768);
                1: load_grid(1, 1, 0, 32767, 32767, 32767);
                2: load_grid(2, 3, 256, 0, 0, 0);
                3: load_grid(255, 1, 40000, 1234, -4321, 77);
                default: load_grid($urandom_range(1, 40), $urandom_range(1, 40),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535));
            endcase
            for (int n = 0; n < 95; n++) begin
                if (ph == 2 && n == 10) squeeze_req = 1'b1;
                random_req();
            end
        end
        s_valid = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
        if (errors == 0)
            $display("[uv_sphere_mesh_generator_unit] OK");
        else
            $display("[uv_sphere_mesh_generator_unit] ERROR");
        $finish;
    end

endmodule
